// ===== rtl/ffra_pkg.sv =====
`default_nettype none

package ffra_pkg;

	localparam int START_W = 24;
	localparam int LEN_W = 25;
	localparam int SUM_W = 26;
	localparam int ADDR_BITS = 24;
	localparam int MAX_RANGES_DEF = 64;

	localparam logic [LEN_W-1:0] CAP_LIM =
		(ADDR_BITS >= LEN_W) ? {LEN_W{1'b1}} : LEN_W'(64'd1 << ADDR_BITS);
	localparam logic [LEN_W-1:0] CAP_RST_RAW = LEN_W'(65536);
	localparam logic [LEN_W-1:0] CAP_RESET =
		(CAP_RST_RAW < CAP_LIM) ? CAP_RST_RAW : CAP_LIM;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE = 2'd1;
	localparam logic [1:0] OP_SHRINK = 2'd2;

	typedef enum logic [1:0] {
		ST_OK,
		ST_NO_ROOM,
		ST_NOT_FOUND,
		ST_FULL
	} status_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic [START_W-1:0] range_start_in;
		logic [LEN_W-1:0]   length;
		logic [LEN_W-1:0]   new_length;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [START_W-1:0] placed_start;
	} rsp_t;

	typedef struct packed {
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   len;
	} entry_t;

	typedef struct packed {
		logic [SUM_W-1:0] end_sum;
		logic             fit_gap;
		logic             end_fit;
		logic             match;
	} unit_res_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_sts_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_SCAN,
		S_END,
		S_PLACE,
		S_SHUP,
		S_WRNEW,
		S_SHDN,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/first_fit_range_allocator.sv =====
// channel   dir  handshake            payload
// req       in   req_valid/req_stall  req_t {operation, range_start_in, length, new_length}
// rsp       out  rsp_valid/rsp_stall  rsp_t {status, placed_start}
// cfg       in   cfg_wen              cfg_wdata: region capacity
//
// One item at a time: an allocate, free or shrink scans the table and may shift
// entries (one scan or shift per entry), and the one-entry-per-cycle table port
// sets the pace; the next item is taken once the result leaves the sequencer.
// Reset empties the table at once (entry count zero) and sets capacity 65536.
// A result waits in the output register while rsp_stall is high; the next item
// is taken meanwhile, and its result waits in the sequencer until the register frees.
`default_nettype none

module first_fit_range_allocator
	import ffra_pkg::*;
#(
	parameter int MAX_RANGES = MAX_RANGES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp,
	input  logic             cfg_wen,
	input  logic [LEN_W-1:0] cfg_wdata
);

	logic [LEN_W-1:0] cap_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	core_sts_t        sts;
	rsp_t             res;
	logic             out_free;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = sts.busy;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	ffra_core #(
		.MAX_RANGES (MAX_RANGES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (req_valid && !sts.busy),
		.req      (req),
		.cap      (cap_q),
		.out_free (out_free),
		.sts      (sts),
		.rsp      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				cap_q <= (cfg_wdata < CAP_LIM) ? cfg_wdata : CAP_LIM;
			end
			if (sts.done) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sts.done) begin
			rsp_q <= res;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ffra_unit.sv =====
`default_nettype none

module ffra_unit
	import ffra_pkg::*;
(
	input  entry_t                   entry,
	input  logic [SUM_W-1:0]         prev_end,
	input  logic [LEN_W-1:0]         need,
	input  logic [START_W-1:0]       key_start,
	input  logic [LEN_W-1:0]         key_len,
	input  logic [LEN_W-1:0]         cap,
	output unit_res_t                res
);

	logic [SUM_W:0] bn;

	always_comb begin
		bn = {1'b0, prev_end} + {2'b00, need};
		res.end_sum = {2'b00, entry.start} + {1'b0, entry.len};
		res.fit_gap = {3'b000, entry.start} >= bn;
		res.end_fit = bn <= {2'b00, cap};
		res.match = (entry.start == key_start) && (entry.len == key_len);
	end

endmodule

`default_nettype wire

// ===== rtl/ffra_core.sv =====
`default_nettype none

module ffra_core
	import ffra_pkg::*;
#(
	parameter int MAX_RANGES = MAX_RANGES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  req_t             req,
	input  logic [LEN_W-1:0] cap,
	input  logic             out_free,
	output core_sts_t        sts,
	output rsp_t             rsp
);

	localparam int IW = $clog2(MAX_RANGES);
	localparam int CW = $clog2(MAX_RANGES + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RANGES);

	state_t             state_q, state_d;
	req_t               req_q, req_d;
	logic [CW-1:0]      count_q, count_d;
	logic [IW-1:0]      idx_q, idx_d;
	logic [CW-1:0]      pos_q, pos_d;
	logic [SUM_W-1:0]   b_q, b_d;
	status_t            st_q, st_d;
	logic [START_W-1:0] place_q, place_d;

	entry_t             mem [MAX_RANGES];
	entry_t             rdata_q;
	logic [IW-1:0]      raddr;
	logic               we;
	logic [IW-1:0]      waddr;
	entry_t             wdata;

	unit_res_t          u;
	logic               last;

	ffra_unit u_unit (
		.entry     (rdata_q),
		.prev_end  (b_q),
		.need      (req_q.length),
		.key_start (req_q.range_start_in),
		.key_len   (req_q.length),
		.cap       (cap),
		.res       (u)
	);

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q   <= req_d;
		idx_q   <= idx_d;
		pos_q   <= pos_d;
		b_q     <= b_d;
		st_q    <= st_d;
		place_q <= place_d;
	end

	always_comb begin
		state_d = state_q;
		req_d   = req_q;
		count_d = count_q;
		idx_d   = idx_q;
		pos_d   = pos_q;
		b_d     = b_q;
		st_d    = st_q;
		place_d = place_q;
		raddr   = '0;
		we      = 1'b0;
		waddr   = idx_q;
		wdata   = rdata_q;
		sts.done = 1'b0;
		last    = (CW'(idx_q) + CW'(1)) == count_q;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					req_d   = req;
					b_d     = '0;
					state_d = S_START;
				end
			end
			S_START: begin
				place_d = '0;
				idx_d   = '0;
				case (req_q.operation)
					OP_ALLOC: begin
						if (req_q.length > cap) begin
							st_d    = ST_NO_ROOM;
							state_d = S_DONE;
						end else if (count_q == '0) begin
							state_d = S_END;
						end else begin
							state_d = S_SCAN;
						end
					end
					OP_FREE, OP_SHRINK: begin
						if (count_q == '0) begin
							st_d    = ST_NOT_FOUND;
							state_d = S_DONE;
						end else begin
							state_d = S_SCAN;
						end
					end
					default: begin
						st_d    = ST_NOT_FOUND;
						state_d = S_DONE;
					end
				endcase
			end
			S_SCAN: begin
				raddr = idx_q + IW'(1);
				if (req_q.operation == OP_ALLOC) begin
					if (u.fit_gap) begin
						pos_d   = CW'(idx_q);
						place_d = b_q[START_W-1:0];
						state_d = S_PLACE;
					end else begin
						b_d = u.end_sum;
						if (last) begin
							state_d = S_END;
						end else begin
							idx_d = idx_q + IW'(1);
						end
					end
				end else if (u.match) begin
					if (req_q.operation == OP_FREE) begin
						if (last) begin
							count_d = count_q - CW'(1);
							st_d    = ST_OK;
							state_d = S_DONE;
						end else begin
							state_d = S_SHDN;
						end
					end else begin
						if (req_q.new_length > req_q.length) begin
							st_d = ST_NO_ROOM;
						end else begin
							we        = 1'b1;
							waddr     = idx_q;
							wdata.start = rdata_q.start;
							wdata.len = req_q.new_length;
							st_d      = ST_OK;
						end
						state_d = S_DONE;
					end
				end else if (last) begin
					st_d    = ST_NOT_FOUND;
					state_d = S_DONE;
				end else begin
					idx_d = idx_q + IW'(1);
				end
			end
			S_END: begin
				if (u.end_fit) begin
					pos_d   = count_q;
					place_d = b_q[START_W-1:0];
					state_d = S_PLACE;
				end else begin
					st_d    = ST_NO_ROOM;
					state_d = S_DONE;
				end
			end
			S_PLACE: begin
				raddr = IW'(count_q - CW'(1));
				if (count_q >= MAX_CNT) begin
					st_d    = ST_FULL;
					place_d = '0;
					state_d = S_DONE;
				end else if (pos_q == count_q) begin
					state_d = S_WRNEW;
				end else begin
					idx_d   = IW'(count_q - CW'(1));
					state_d = S_SHUP;
				end
			end
			S_SHUP: begin
				we    = 1'b1;
				waddr = idx_q + IW'(1);
				wdata = rdata_q;
				raddr = idx_q - IW'(1);
				if (CW'(idx_q) == pos_q) begin
					state_d = S_WRNEW;
				end else begin
					idx_d = idx_q - IW'(1);
				end
			end
			S_WRNEW: begin
				we          = 1'b1;
				waddr       = IW'(pos_q);
				wdata.start = place_q;
				wdata.len   = req_q.length;
				count_d     = count_q + CW'(1);
				st_d        = ST_OK;
				state_d     = S_DONE;
			end
			S_SHDN: begin
				we    = 1'b1;
				waddr = idx_q;
				wdata = rdata_q;
				raddr = idx_q + IW'(2);
				if ((CW'(idx_q) + CW'(2)) == count_q) begin
					count_d = count_q - CW'(1);
					st_d    = ST_OK;
					state_d = S_DONE;
				end else begin
					idx_d = idx_q + IW'(1);
				end
			end
			S_DONE: begin
				if (out_free) begin
					sts.done = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		sts.busy = state_q != S_IDLE;
		rsp.status = st_q;
		rsp.placed_start = (st_q == ST_OK && req_q.operation == OP_ALLOC) ? place_q : '0;
	end

endmodule

`default_nettype wire

// ===== tb/sv/first_fit_range_allocator_checker.sv =====
module first_fit_range_allocator_checker
	import ffra_pkg::*;
#(
	parameter int MAX_RANGES = MAX_RANGES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic             req_stall,
	input  req_t             req,
	input  logic             rsp_valid,
	input  logic             rsp_stall,
	input  rsp_t             rsp,
	input  logic             cfg_wen,
	input  logic [LEN_W-1:0] cfg_wdata,
	output int               fail_count,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SHOW_LIMIT = 10;

	entry_t           tbl [MAX_RANGES];
	int               n_used;
	logic [LEN_W-1:0] cap_reg;
	rsp_t             owed_rsp [$];
	int               shown;

	function automatic logic [SUM_W:0] usable_capacity();
		logic [63:0] lim;
		lim = 64'd1 << ADDR_BITS;
		return (64'(cap_reg) < lim) ? (SUM_W+1)'(cap_reg) : (SUM_W+1)'(lim);
	endfunction

	function automatic int find_range(input logic [START_W-1:0] s, input logic [LEN_W-1:0] l);
		for (int i = 0; i < n_used; i++) begin
			if (tbl[i].start == s && tbl[i].len == l)
				return i;
		end
		return -1;
	endfunction

	function automatic status_t place_first_fit(input logic [LEN_W-1:0] n,
			output logic [START_W-1:0] at);
		logic [SUM_W:0]     room;
		logic [SUM_W:0]     lo;
		logic [SUM_W:0]     hi;
		logic [START_W-1:0] where_at;
		int                 pos;
		bit                 fit;
		at = '0;
		room = usable_capacity();
		where_at = '0;
		pos = 0;
		fit = 1'b0;
		if (n > room)
			return ST_NO_ROOM;
		if (n_used == 0 || tbl[0].start >= n) begin
			fit = 1'b1;
		end else begin
			for (int i = 0; i + 1 < n_used && !fit; i++) begin
				lo = tbl[i].start + tbl[i].len;
				hi = tbl[i+1].start;
				if (hi >= lo && hi - lo >= n) begin
					where_at = lo[START_W-1:0];
					pos = i + 1;
					fit = 1'b1;
				end
			end
			if (!fit) begin
				lo = tbl[n_used-1].start + tbl[n_used-1].len;
				if (lo + n <= room) begin
					where_at = lo[START_W-1:0];
					pos = n_used;
					fit = 1'b1;
				end
			end
		end
		if (!fit)
			return ST_NO_ROOM;
		if (n_used >= MAX_RANGES)
			return ST_FULL;
		for (int i = n_used; i > pos; i--)
			tbl[i] = tbl[i-1];
		tbl[pos] = '{start: where_at, len: n};
		n_used++;
		at = where_at;
		return ST_OK;
	endfunction

	function automatic rsp_t serve_request(input req_t r);
		rsp_t               o;
		int                 k;
		logic [START_W-1:0] at;
		o.status = ST_NOT_FOUND;
		o.placed_start = '0;
		at = '0;
		case (r.operation)
			OP_ALLOC: begin
				o.status = place_first_fit(r.length, at);
				o.placed_start = at;
			end
			OP_FREE: begin
				k = find_range(r.range_start_in, r.length);
				if (k >= 0) begin
					for (int i = k; i + 1 < n_used; i++)
						tbl[i] = tbl[i+1];
					n_used--;
					o.status = ST_OK;
				end
			end
			OP_SHRINK: begin
				k = find_range(r.range_start_in, r.length);
				if (k >= 0) begin
					if (r.new_length > r.length) begin
						o.status = ST_NO_ROOM;
					end else begin
						tbl[k].len = r.new_length;
						o.status = ST_OK;
					end
				end
			end
			default: ;
		endcase
		if (!(o.status == ST_OK && r.operation == OP_ALLOC))
			o.placed_start = '0;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			n_used = 0;
			cap_reg = LEN_W'(65536);
			owed_rsp.delete();
			fail_count = 0;
			shown = 0;
		end else begin
			if (cfg_wen)
				cap_reg = cfg_wdata;
			if (rsp_valid && !rsp_stall) begin
				if (owed_rsp.size() == 0) begin
					fail_count++;
					if (shown < SHOW_LIMIT)
						$display("unexpected item: status %0d start %h", rsp.status,
							rsp.placed_start);
					shown++;
				end else begin
					want = owed_rsp.pop_front();
					if (rsp.status !== want.status || rsp.placed_start !== want.placed_start) begin
						fail_count++;
						if (shown < SHOW_LIMIT)
							$display("mismatch: expected status %0d start %h, got status %0d start %h",
								want.status, want.placed_start, rsp.status, rsp.placed_start);
						shown++;
					end
				end
			end
			if (req_valid && !req_stall)
				owed_rsp.push_back(serve_request(req));
		end
		pending = owed_rsp.size();
	end

endmodule

// ===== tb/sv/first_fit_range_allocator_tb.sv =====
module first_fit_range_allocator_tb;
	import ffra_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH = MAX_RANGES_DEF;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 80;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 300;
	localparam int unsigned LEN_TOP = 16777216;

	logic             clk;
	logic             arst_n;
	logic             req_valid;
	logic             req_stall;
	req_t             req;
	logic             rsp_valid;
	logic             rsp_stall;
	rsp_t             rsp;
	logic             cfg_wen;
	logic [LEN_W-1:0] cfg_wdata;
	int               fail_count;
	int               pending;

	req_t             sent_q [$];
	entry_t           live_ranges [$];
	int               burst_left;
	int unsigned      cap_now;

	first_fit_range_allocator #(
		.MAX_RANGES(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	first_fit_range_allocator_checker #(
		.MAX_RANGES(TABLE_DEPTH)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("Verification failed");
		$finish;
	end

	// ranges known to be live, so most frees and shrinks hit
	always @(posedge clk) begin
		req_t r;
		if (arst_n && rsp_valid && !rsp_stall && sent_q.size() != 0) begin
			r = sent_q.pop_front();
			if (r.operation == OP_ALLOC && rsp.status == ST_OK)
				live_ranges.push_back('{start: rsp.placed_start, len: r.length});
		end
	end

	// receiver: random stall modes plus a long hold now and then
	initial begin
		int cyc;
		int mode;
		int mode_left;
		int hold_left;
		cyc = 0;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		rsp_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc % 40000 == 6000)
				hold_left = 400;
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall = 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 300);
				end
				mode_left--;
				case (mode)
					0: rsp_stall = 1'b0;
					1: rsp_stall = ($urandom_range(0, 3) == 0);
					2: rsp_stall = ($urandom_range(0, 3) != 0);
					default: rsp_stall = cyc[2];
				endcase
			end
		end
	end

	function automatic req_t mk(input logic [1:0] op, input logic [START_W-1:0] s,
			input logic [LEN_W-1:0] l, input logic [LEN_W-1:0] nl);
		req_t r;
		r.operation = op;
		r.range_start_in = s;
		r.length = l;
		r.new_length = nl;
		return r;
	endfunction

	task automatic offer(input req_t r);
		req = r;
		req_valid = 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sent_q.push_back(r);
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(0, 15);
			if ($urandom_range(0, 3) != 0) begin
				req_valid = 1'b0;
				if ($urandom_range(0, 9) == 0)
					repeat ($urandom_range(50, 200)) @(negedge clk);
				else
					repeat ($urandom_range(1, 12)) @(negedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic drain();
		req_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_capacity(input int unsigned v);
		drain();
		cfg_wdata = LEN_W'(v);
		cfg_wen = 1'b1;
		@(negedge clk);
		cfg_wen = 1'b0;
		cap_now = v;
	endtask

	function automatic logic [LEN_W-1:0] rand_len(input int unsigned len_max);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 80)
			return LEN_W'($urandom_range(0, len_max));
		if (roll < 88)
			return LEN_W'($urandom_range(0, cap_now));
		if (roll < 93)
			return LEN_W'(cap_now);
		if (roll < 96)
			return LEN_W'((cap_now < LEN_TOP) ? cap_now + 1 : LEN_TOP);
		return LEN_W'($urandom_range(0, LEN_TOP));
	endfunction

	task automatic next_request(input int alloc_pct, input int unsigned len_max,
			output req_t r);
		int     roll;
		int     k;
		entry_t e;
		r.operation = OP_ALLOC;
		r.range_start_in = START_W'($urandom);
		r.length = rand_len(len_max);
		r.new_length = LEN_W'($urandom_range(0, LEN_TOP));
		roll = $urandom_range(0, 99);
		if (roll < 4) begin
			r.operation = 2'($urandom_range(0, 2));
			r.length = LEN_W'($urandom_range(0, LEN_TOP));
		end else if (roll >= alloc_pct && live_ranges.size() != 0) begin
			k = $urandom_range(0, live_ranges.size() - 1);
			e = live_ranges[k];
			r.range_start_in = e.start;
			r.length = e.len;
			if ($urandom_range(0, 9) == 0) begin
				// near miss on start or length
				r.operation = $urandom_range(0, 1) ? OP_FREE : OP_SHRINK;
				if ($urandom_range(0, 1))
					r.range_start_in = e.start ^ (START_W'(1) << $urandom_range(0, START_W - 1));
				else
					r.length = e.len + 1'b1;
			end else if ($urandom_range(0, 99) < 60) begin
				r.operation = OP_FREE;
				live_ranges.delete(k);
			end else begin
				r.operation = OP_SHRINK;
				if ($urandom_range(0, 7) == 0) begin
					r.new_length = e.len + LEN_W'($urandom_range(1, 100));
				end else begin
					r.new_length = LEN_W'($urandom_range(0, e.len));
					live_ranges[k].len = r.new_length;
				end
			end
		end
	endtask

	initial begin
		int unsigned phase_cap [PHASES];
		int          phase_alloc [PHASES];
		int unsigned phase_len [PHASES];
		req_t        r;
		phase_cap = '{1000, 16777216, 1, 65536, 0, 200};
		phase_alloc = '{60, 65, 50, 85, 50, 55};
		phase_len = '{40, 262144, 2, 64, 0, 30};
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		burst_left = 0;
		cap_now = 65536;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		offer(mk(OP_ALLOC, 24'd0, 25'd65537, 25'd0));
		offer(mk(OP_ALLOC, 24'hFFFFFF, 25'h1000000, 25'h1000000));
		offer(mk(OP_ALLOC, 24'd0, 25'd0, 25'd0));
		offer(mk(OP_ALLOC, 24'd0, 25'd100, 25'd0));
		offer(mk(OP_ALLOC, 24'd0, 25'd200, 25'd0));
		offer(mk(OP_FREE, 24'd0, 25'd100, 25'd0));
		offer(mk(OP_ALLOC, 24'd0, 25'd50, 25'd0));
		offer(mk(OP_FREE, 24'd5000, 25'd3, 25'd0));
		offer(mk(OP_SHRINK, 24'd100, 25'd200, 25'd300));
		offer(mk(OP_SHRINK, 24'd100, 25'd200, 25'd150));
		offer(mk(OP_SHRINK, 24'd100, 25'd150, 25'd0));
		offer(mk(OP_ALLOC, 24'd0, 25'd65436, 25'd0));
		offer(mk(OP_ALLOC, 24'd0, 25'd1, 25'd0));
		offer(mk(OP_ALLOC, 24'd0, 25'd60, 25'd0));
		offer(mk(OP_UNUSED, 24'd100, 25'd0, 25'd0));
		offer(mk(OP_ALLOC, 24'd0, 25'd0, 25'd0));
		offer(mk(OP_FREE, 24'd0, 25'd0, 25'd0));
		offer(mk(OP_FREE, 24'd100, 25'd65436, 25'd0));
		offer(mk(OP_FREE, 24'hFFFFFF, 25'h1000000, 25'h1000000));
		write_capacity(1);
		offer(mk(OP_ALLOC, 24'd0, 25'd2, 25'd0));
		offer(mk(OP_ALLOC, 24'd0, 25'd1, 25'd0));
		write_capacity(16777216);
		offer(mk(OP_ALLOC, 24'd0, 25'h1000000, 25'd0));
		offer(mk(OP_ALLOC, 24'd0, 25'hFFFF00, 25'd0));

		for (int p = 0; p < PHASES; p++) begin
			if (phase_cap[p] == 0) begin
				phase_cap[p] = $urandom_range(2, 16777215);
				phase_len[p] = phase_cap[p] / 16;
			end
			write_capacity(phase_cap[p]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				next_request(phase_alloc[p], phase_len[p], r);
				offer(r);
			end
		end

		drain();
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/ffra_pkg.sv
rtl/ffra_unit.sv
rtl/ffra_core.sv
rtl/first_fit_range_allocator.sv
tb/sv/first_fit_range_allocator_checker.sv
tb/sv/first_fit_range_allocator_tb.sv
